### src/assert_macros.svh
// assertion macros for the rtl files, included by rational_arithmetic_unit.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

### src/rau_pkg.sv
// types and constants for the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} rau_in_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic signed [31:0] res_den;
		logic               overflow;
	} rau_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_ADD, ST_GCD_INIT, ST_GCD,
		ST_DIV_N, ST_DIV_D, ST_DONE
	} rau_state_t;
endpackage
`default_nettype wire

### src/rau_divider.sv
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on nothing
`default_nettype none
module rau_divider #(
	parameter int W = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          go,
	input  wire  [W-1:0] dividend,
	input  wire  [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;

	// one shift-subtract step
	assign trial = {rem, quot[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			quot  <= dividend;
			rem   <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem  <= trial[W-1:0];
				quot <= {quot[W-2:0], 1'b1};
			end else begin
				rem  <= {rem[W-2:0], quot[W-1]};
				quot <= {quot[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### src/rational_arithmetic_unit.sv
// rational arithmetic unit: cross products, euclid gcd, exact reduction
// sequence: cross products in MUL1, MUL2 and MUL3 (MUL3 skipped for multiply and divide),
// sum in ADD, GCD_INIT, one divider remainder per euclid step in GCD up to a zero check,
// exact divisions by the gcd in DIV_N and DIV_D, and the done state
// zero product denominator after multiply or divide: ADD goes straight to done
// throughput: one word at a time, busy high for the whole item; reset clears control only
`default_nettype none
`include "assert_macros.svh"
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire rau_pkg::rau_in_t din,
	output logic               busy,
	output logic               done,
	output rau_pkg::rau_out_t  dout
);
	rau_pkg::rau_state_t st_q, st_d;
	logic [1:0]       op_q;
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic [WIDTH-1:0] p1_q, p2_q, n_q, d_q, x_q, y_q, g_q;
	logic             ovf_q;
	logic [WIDTH-1:0] ma, mb, mp;
	logic [2*WIDTH-1:0] prod;
	logic             mwrap;
	logic [WIDTH:0]   sum;
	logic             sovf;
	logic             dgo, ddone;
	logic [WIDTH-1:0] dnd, dvs, dq, dr;
	logic             dvalid_q;

	function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
		return v[WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// shared multiplier operand select
	always_comb begin
		ma = an_q; mb = bd_q;
		unique case (st_q)
			rau_pkg::ST_MUL1: begin
				ma = an_q;
				mb = (op_q == rau_pkg::OP_MUL) ? bn_q : bd_q;
			end
			rau_pkg::ST_MUL2: begin
				ma = (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV) ? ad_q : bn_q;
				mb = (op_q == rau_pkg::OP_MUL) ? bd_q :
				     (op_q == rau_pkg::OP_DIV) ? bn_q : ad_q;
			end
			default: begin
				ma = ad_q; mb = bd_q;
			end
		endcase
	end
	assign prod  = (2*WIDTH)'($signed(ma)) * (2*WIDTH)'($signed(mb));
	assign mp    = prod[WIDTH-1:0];
	assign mwrap = prod[2*WIDTH-1:WIDTH] != {WIDTH{prod[WIDTH-1]}};

	assign sum  = (op_q == rau_pkg::OP_SUB) ? {p1_q[WIDTH-1], p1_q} - {p2_q[WIDTH-1], p2_q}
	                                        : {p1_q[WIDTH-1], p1_q} + {p2_q[WIDTH-1], p2_q};
	assign sovf = sum[WIDTH] != sum[WIDTH-1];

	// shared divider: euclid remainders and final exact divisions
	always_comb begin
		dgo = 1'b0; dnd = x_q; dvs = y_q;
		unique case (st_q)
			rau_pkg::ST_GCD:   begin dgo = !dvalid_q && y_q != '0; end
			rau_pkg::ST_DIV_N: begin dgo = !dvalid_q; dnd = mag(n_q); dvs = g_q; end
			rau_pkg::ST_DIV_D: begin dgo = !dvalid_q; dnd = mag(d_q); dvs = g_q; end
			default: ;
		endcase
	end

	rau_divider #(.W(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dgo), .dividend(dnd), .divisor(dvs),
		.done(ddone), .quot(dq), .rem(dr)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rau_pkg::ST_IDLE:     if (start) st_d = rau_pkg::ST_MUL1;
			rau_pkg::ST_MUL1:     st_d = rau_pkg::ST_MUL2;
			rau_pkg::ST_MUL2:     st_d = (op_q[1]) ? rau_pkg::ST_ADD : rau_pkg::ST_MUL3;
			rau_pkg::ST_MUL3:     st_d = rau_pkg::ST_ADD;
			rau_pkg::ST_ADD:      st_d = (op_q[1] && d_q == '0) ? rau_pkg::ST_DONE
			                                                   : rau_pkg::ST_GCD_INIT;
			rau_pkg::ST_GCD_INIT: st_d = rau_pkg::ST_GCD;
			rau_pkg::ST_GCD: begin
				if (y_q == '0 && !dvalid_q)
					st_d = (x_q == '0) ? rau_pkg::ST_DONE : rau_pkg::ST_DIV_N;
			end
			rau_pkg::ST_DIV_N:    if (ddone) st_d = rau_pkg::ST_DIV_D;
			rau_pkg::ST_DIV_D:    if (ddone) st_d = rau_pkg::ST_DONE;
			rau_pkg::ST_DONE:     st_d = rau_pkg::ST_IDLE;
			default:              st_d = rau_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = st_q != rau_pkg::ST_IDLE;
		done = st_q == rau_pkg::ST_DONE;
		dout.res_num  = 32'($signed(n_q));
		dout.res_den  = 32'($signed(d_q));
		dout.overflow = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= rau_pkg::ST_IDLE;
			dvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (dgo) dvalid_q <= 1'b1;
			else if (ddone) dvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			rau_pkg::ST_IDLE: if (start) begin
				op_q  <= din.opcode;
				an_q  <= WIDTH'(din.a_num);
				ad_q  <= WIDTH'(din.a_den);
				bn_q  <= WIDTH'(din.b_num);
				bd_q  <= WIDTH'(din.b_den);
				ovf_q <= 1'b0;
			end
			rau_pkg::ST_MUL1: begin
				p1_q <= mp; ovf_q <= ovf_q | mwrap;
			end
			rau_pkg::ST_MUL2: begin
				p2_q <= mp; ovf_q <= ovf_q | mwrap;
				if (op_q[1]) begin d_q <= mp; n_q <= p1_q; end
			end
			rau_pkg::ST_MUL3: begin
				d_q <= mp; ovf_q <= ovf_q | mwrap;
			end
			rau_pkg::ST_ADD: begin
				if (!op_q[1]) begin
					n_q <= sum[WIDTH-1:0]; ovf_q <= ovf_q | sovf;
				end else if (d_q == '0) begin
					d_q <= WIDTH'(1);
				end
			end
			rau_pkg::ST_GCD_INIT: begin
				x_q <= mag(n_q); y_q <= mag(d_q);
			end
			rau_pkg::ST_GCD: begin
				if (ddone) begin x_q <= y_q; y_q <= dr; end
				g_q <= x_q;
			end
			rau_pkg::ST_DIV_N: if (ddone) n_q <= n_q[WIDTH-1] ? (~dq + 1'b1) : dq;
			rau_pkg::ST_DIV_D: if (ddone) d_q <= d_q[WIDTH-1] ? (~dq + 1'b1) : dq;
			default: ;
		endcase
	end

	`ASSERT_IMPL(a_done_one_cycle, clk, arst_n, done |=> !done)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPL(a_div_in_reduce, clk, arst_n, ddone |-> busy)
endmodule
`default_nettype wire
